// ===== design/mlr_pkg.sv =====
// Package for the matrix line rotator: field widths, request kinds,
// register indexes and sequencer states. It depends on nothing else.
`default_nettype none

package mlr_pkg;

    localparam int IDX_W       = 5;
    localparam int VALUE_W     = 32;
    localparam int AMOUNT_W    = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_IN_USE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_IN_USE = 4'd1;
    localparam logic [CFG_DATA_W-1:0]  CFG_DIM_RESET   = 6'd32;

    localparam logic DIR_TOWARD_HIGH = 1'b0;
    localparam logic DIR_TOWARD_LOW  = 1'b1;

    typedef enum logic [1:0]
    {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_ROT_ROW = 2'd2,
        KIND_ROT_COL = 2'd3
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_RD_RESP,
        ST_MOD,
        ST_START,
        ST_LOAD,
        ST_STORE
    } state_t;

endpackage

`default_nettype wire

// ===== design/mlr_cfg_if.sv =====
// Configuration write channel of the matrix line rotator.
// Depends on mlr_pkg for the index and data widths.
`default_nettype none

interface mlr_cfg_if
    import mlr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/mlr_req_if.sv =====
// Request channel of the matrix line rotator.
// Depends on mlr_pkg for the field widths and the kind type.
`default_nettype none

interface mlr_req_if
    import mlr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    kind_t                      kind;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [VALUE_W-1:0]  value;
    logic [IDX_W-1:0]           line_index;
    logic [AMOUNT_W-1:0]        amount;
    logic                       direction;

    modport source (output valid, output kind, output row, output col, output value,
                    output line_index, output amount, output direction, input ready);
    modport sink   (input valid, input kind, input row, input col, input value,
                    input line_index, input amount, input direction, output ready);
endinterface

`default_nettype wire

// ===== design/mlr_resp_if.sv =====
// Response channel of the matrix line rotator, one word per read request.
// Depends on mlr_pkg for the value width.
`default_nettype none

interface mlr_resp_if
    import mlr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] read_value;

    modport source (output valid, output read_value, input ready);
    modport sink   (input valid, input read_value, output ready);
endinterface

`default_nettype wire

// ===== design/matrix_line_rotator_top.sv =====
// Matrix line rotator top level: matrix memory, line buffer and sequencer.
// Depends on mlr_pkg and the interfaces mlr_cfg_if, mlr_req_if, mlr_resp_if.
//
//   channel  role    payload
//   cfg      sink    index, data (rows_in_use, cols_in_use)
//   req      sink    kind, row, col, value, line_index, amount, direction
//   resp     source  read_value, one per read request
//
// A write is done in its request cycle and a read passes through its response
// state, plus any wait for the response register. A rotate takes the request
// cycle, the remainder steps in the shared remainder unit, a start state, then
// a load pass and a store pass over the line through the single-port matrix memory.
// Reset clears control state only; matrix contents are undefined until written.
// A read waits in its response state while the previous response is not taken.
`default_nettype none

module matrix_line_rotator_top
    import mlr_pkg::*;
#(
    parameter int MAX_DIM    = 32,
    parameter int DATA_WIDTH = 32
)
(
    input  wire        clk,
    input  wire        rst_n,
    mlr_cfg_if.sink    cfg,
    mlr_req_if.sink    req,
    mlr_resp_if.source resp
);

    localparam int LW    = $clog2(MAX_DIM + 1);
    localparam int UW    = LW + 1;
    localparam int IW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(AMOUNT_W);

    function automatic logic [AW-1:0] elem_addr(input int r, input int c);
        elem_addr = AW'(r * MAX_DIM + c);
    endfunction

    state_t                  state_reg, state_next;
    logic [CFG_DATA_W-1:0]   rows_reg, cols_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]      out_data_reg, out_data_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    inside_reg, inside_next;
    logic [IDX_W-1:0]        line_reg, line_next;
    logic [LW-1:0]           len_reg, len_next;
    logic                    left_reg, left_next;
    logic                    is_col_reg, is_col_next;
    logic [AMOUNT_W-1:0]     amt_reg, amt_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [LW-1:0]           rem_reg, rem_next;
    logic [LW-1:0]           src_reg, src_next;
    logic [LW-1:0]           idx_reg, idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [IW-1:0]           pend_idx_reg, pend_idx_next;

    logic [DATA_WIDTH-1:0]   mat_mem [DEPTH];
    logic [DATA_WIDTH-1:0]   line_mem [MAX_DIM];
    logic [DATA_WIDTH-1:0]   mem_rdata_reg;
    logic [DATA_WIDTH-1:0]   buf_rdata_reg;

    logic [AW-1:0]           mem_addr;
    logic                    mem_we;
    logic [DATA_WIDTH-1:0]   mem_wdata;
    logic                    buf_we;

    logic [LW-1:0]           nr, nc;
    logic                    req_fire;
    logic                    elem_inside;
    logic [UW-1:0]           unit_a, unit_out;

    assign nr = (int'(rows_reg) > MAX_DIM) ? LW'(MAX_DIM) : LW'(rows_reg);
    assign nc = (int'(cols_reg) > MAX_DIM) ? LW'(MAX_DIM) : LW'(cols_reg);

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign resp.valid = out_valid_reg;
    assign resp.read_value = signed'(out_data_reg);

    assign elem_inside = (int'(req.row) < int'(nr)) && (int'(req.col) < int'(nc));

    // The shared unit: one conditional subtraction of the line length.
    assign unit_out = (unit_a >= {1'b0, len_reg}) ? (unit_a - {1'b0, len_reg}) : unit_a;

    always_comb
    begin
        unique case (state_reg)
            ST_MOD:   unit_a = {rem_reg, amt_reg[AMOUNT_W-1]};
            ST_START: unit_a = {1'b0, len_reg - rem_reg};
            default:  unit_a = {1'b0, src_reg} + UW'(1);
        endcase
    end

    always_comb
    begin
        mem_addr  = addr_reg;
        mem_we    = 1'b0;
        mem_wdata = buf_rdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_addr  = elem_addr(int'(req.row), int'(req.col));
                mem_we    = req_fire && (req.kind == KIND_WRITE) && elem_inside;
                mem_wdata = DATA_WIDTH'(req.value);
            end
            ST_LOAD:
            begin
                mem_addr = is_col_reg ? elem_addr(int'(idx_reg), int'(line_reg))
                                      : elem_addr(int'(line_reg), int'(idx_reg));
            end
            ST_STORE:
            begin
                mem_addr = is_col_reg ? elem_addr(int'(pend_idx_reg), int'(line_reg))
                                      : elem_addr(int'(line_reg), int'(pend_idx_reg));
                mem_we   = pend_valid_reg;
            end
            default:
            begin
                mem_addr = addr_reg;
            end
        endcase
    end

    assign buf_we = (state_reg == ST_LOAD) && pend_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mat_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mat_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            line_mem[pend_idx_reg] <= mem_rdata_reg;
        end
        buf_rdata_reg <= line_mem[src_reg[IW-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !resp.ready;
        out_data_next   = out_data_reg;
        addr_next       = addr_reg;
        inside_next     = inside_reg;
        line_next       = line_reg;
        len_next        = len_reg;
        left_next       = left_reg;
        is_col_next     = is_col_reg;
        amt_next        = amt_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        src_next        = src_reg;
        idx_next        = idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                left_next = (req.direction == DIR_TOWARD_LOW);
                line_next = req.line_index;
                amt_next  = req.amount;
                cnt_next  = '1;
                rem_next  = '0;
                if (req_fire)
                begin
                    unique case (req.kind)
                        KIND_WRITE:
                        begin
                            state_next = ST_IDLE;
                        end
                        KIND_READ:
                        begin
                            addr_next   = elem_addr(int'(req.row), int'(req.col));
                            inside_next = elem_inside;
                            state_next  = ST_RD_RESP;
                        end
                        KIND_ROT_ROW:
                        begin
                            len_next    = nc;
                            is_col_next = 1'b0;
                            if ((int'(req.line_index) < int'(nr)) && (nc != '0))
                            begin
                                state_next = ST_MOD;
                            end
                        end
                        KIND_ROT_COL:
                        begin
                            len_next    = nr;
                            is_col_next = 1'b1;
                            if ((int'(req.line_index) < int'(nc)) && (nr != '0))
                            begin
                                state_next = ST_MOD;
                            end
                        end
                    endcase
                end
            end
            ST_RD_RESP:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = inside_reg ? VALUE_W'(mem_rdata_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                rem_next = unit_out[LW-1:0];
                amt_next = {amt_reg[AMOUNT_W-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                src_next   = left_reg ? rem_reg : unit_out[LW-1:0];
                idx_next   = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (idx_reg == len_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_STORE;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg[IW-1:0];
                    idx_next        = idx_reg + LW'(1);
                end
            end
            ST_STORE:
            begin
                if (idx_reg == len_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg[IW-1:0];
                    idx_next        = idx_reg + LW'(1);
                    src_next        = unit_out[LW-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rows_reg       <= CFG_DIM_RESET;
            cols_reg       <= CFG_DIM_RESET;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ROWS_IN_USE)
                begin
                    rows_reg <= cfg.data;
                end
                else if (cfg.index == CFG_COLS_IN_USE)
                begin
                    cols_reg <= cfg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        addr_reg     <= addr_next;
        inside_reg   <= inside_next;
        line_reg     <= line_next;
        len_reg      <= len_next;
        left_reg     <= left_next;
        is_col_reg   <= is_col_next;
        amt_reg      <= amt_next;
        rem_reg      <= rem_next;
        src_reg      <= src_next;
        pend_idx_reg <= pend_idx_next;
    end

`ifndef ASSERT_OFF
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |-> (rem_reg < len_reg))
        else $error("remainder not below the line length");

    a_src_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> (src_reg < len_reg))
        else $error("source pointer outside the line");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD || state_reg == ST_STORE) |-> (idx_reg <= len_reg))
        else $error("element counter ran past the line length");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_RESP && (!out_valid_reg || resp.ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("read response not loaded");
`endif

endmodule

`default_nettype wire
